[rtl/cps_pkg.sv]
// Shared types and constants for the closest-point-on-segment pipeline.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps

package cps_pkg;

  localparam int LAT_W  = 28;             // latitude coordinate width
  localparam int LNG_W  = 29;             // longitude coordinate width
  localparam int DLAT_W = LAT_W + 1;      // latitude difference width
  localparam int DLNG_W = LNG_W + 1;      // longitude difference width
  localparam int NUM_W  = 2 * DLNG_W + 1; // signed dot product AP.AB
  localparam int DEN_W  = 2 * DLNG_W;     // unsigned AB.AB
  localparam int QW     = DLNG_W;         // quotient bits, covers any |AB| component
  localparam int HALF_W = DEN_W / 2;      // split of num for the partial products
  localparam int PW     = DEN_W + QW;     // num * |diff|
  localparam int QS_W   = QW + 2;         // signed quotient plus coordinate headroom

  typedef enum logic [1:0] {
    WHERE_INTERIOR = 2'd0,
    WHERE_CLAMP_A  = 2'd1,
    WHERE_CLAMP_B  = 2'd2,
    WHERE_DEGEN    = 2'd3
  } where_e;

  // Values that ride along with a request through the pipeline.
  typedef struct packed {
    logic signed [LAT_W-1:0] a_lat;
    logic signed [LNG_W-1:0] a_lng;
    logic signed [LAT_W-1:0] b_lat;
    logic signed [LNG_W-1:0] b_lng;
    where_e                  where;
    logic [DEN_W-1:0]        den;
  } cps_ctx_t;

  // Per-coordinate state of the restoring divider.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    dvd;
    logic [QW-1:0]    quo;
    logic             neg;
  } cps_lane_t;

endpackage

[rtl/closest_point_on_segment_core.sv]
// Top level of the closest-point-on-segment pipeline.
// Depends on cps_pkg, cps_front, cps_div_stage and cps_back.
`timescale 1ns / 1ps
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  request   | p_lat_i p_lng_i a_lat_i a_lng_i b_lat_i   | start_i high, busy_o low
//            | b_lng_i                                   |
//  result    | near_lat_o near_lng_o where_code_o        | done_o high for one cycle
//
// One request is taken every cycle; busy_o stays low. The result of a request
// passes through five front stages (differences, products, dot products, partial
// products, their sum), one stage per quotient bit of the 30-step restoring divider,
// and two stages for sign fixing and rounding.
// Reset clears only the valid bits. The receiver cannot stall, so nothing holds.

module closest_point_on_segment_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [cps_pkg::LAT_W-1:0] p_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0] p_lng_i,
  input  logic signed [cps_pkg::LAT_W-1:0] a_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0] a_lng_i,
  input  logic signed [cps_pkg::LAT_W-1:0] b_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0] b_lng_i,
  output logic                             done_o,
  output logic signed [cps_pkg::LAT_W-1:0] near_lat_o,
  output logic signed [cps_pkg::LNG_W-1:0] near_lng_o,
  output logic [1:0]                       where_code_o
);

  localparam int QW = cps_pkg::QW;

  logic               vld_c [QW+1];
  cps_pkg::cps_ctx_t  ctx_c [QW+1];
  cps_pkg::cps_lane_t lat_c [QW+1];
  cps_pkg::cps_lane_t lng_c [QW+1];

  assign busy_o = 1'b0;

  cps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .p_lat_i (p_lat_i),
    .p_lng_i (p_lng_i),
    .a_lat_i (a_lat_i),
    .a_lng_i (a_lng_i),
    .b_lat_i (b_lat_i),
    .b_lng_i (b_lng_i),
    .valid_o (vld_c[0]),
    .ctx_o   (ctx_c[0]),
    .lat_o   (lat_c[0]),
    .lng_o   (lng_c[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_div
    cps_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[i]),
      .ctx_i   (ctx_c[i]),
      .lat_i   (lat_c[i]),
      .lng_i   (lng_c[i]),
      .valid_o (vld_c[i+1]),
      .ctx_o   (ctx_c[i+1]),
      .lat_o   (lat_c[i+1]),
      .lng_o   (lng_c[i+1])
    );
  end

  cps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (vld_c[QW]),
    .ctx_i        (ctx_c[QW]),
    .lat_i        (lat_c[QW]),
    .lng_i        (lng_c[QW]),
    .valid_o      (done_o),
    .near_lat_o   (near_lat_o),
    .near_lng_o   (near_lng_o),
    .where_code_o (where_code_o)
  );

endmodule

[rtl/cps_front.sv]
// Front pipeline: differences, dot products, clamp decision and num*|diff|.
// Five register stages; depends on cps_pkg.
`timescale 1ns / 1ps

module cps_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [cps_pkg::LAT_W-1:0]  p_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0]  p_lng_i,
  input  logic signed [cps_pkg::LAT_W-1:0]  a_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0]  a_lng_i,
  input  logic signed [cps_pkg::LAT_W-1:0]  b_lat_i,
  input  logic signed [cps_pkg::LNG_W-1:0]  b_lng_i,
  output logic                              valid_o,
  output cps_pkg::cps_ctx_t                 ctx_o,
  output cps_pkg::cps_lane_t                lat_o,
  output cps_pkg::cps_lane_t                lng_o
);

  localparam int LAT_W  = cps_pkg::LAT_W;
  localparam int LNG_W  = cps_pkg::LNG_W;
  localparam int DLAT_W = cps_pkg::DLAT_W;
  localparam int DLNG_W = cps_pkg::DLNG_W;
  localparam int NUM_W  = cps_pkg::NUM_W;
  localparam int DEN_W  = cps_pkg::DEN_W;
  localparam int QW     = cps_pkg::QW;
  localparam int HALF_W = cps_pkg::HALF_W;
  localparam int PW     = cps_pkg::PW;

  logic [4:0] vld_q;

  // Stage 1: differences.
  cps_pkg::cps_ctx_t          c1_q, c2_q, c3_q, c4_q, c5_q;
  cps_pkg::cps_ctx_t          c3_d, c4_d;
  logic signed [DLAT_W-1:0]   dxp_q, dxb1_q, dxb2_q, dxb3_q;
  logic signed [DLNG_W-1:0]   dyp_q, dyb1_q, dyb2_q, dyb3_q;
  logic                       degen1_q, degen2_q, degen3_q;
  // Stage 2: products.
  logic signed [2*DLAT_W-1:0] pxx_q, bxx_q;
  logic signed [2*DLNG_W-1:0] pyy_q, byy_q;
  // Stage 3: num and den.
  logic signed [NUM_W-1:0]    num_q;
  // Stage 4: partial products.
  logic [2*QW-1:0]            lat_lo_q, lat_hi_q, lng_lo_q, lng_hi_q;
  logic                       lat_neg4_q, lng_neg4_q;

  logic [QW-1:0]              mag_lat, mag_lng;
  logic [DEN_W-1:0]           num_u;
  logic [PW-1:0]              prod_lat, prod_lng;
  cps_pkg::where_e            where_d;

  always_comb begin
    mag_lat = dxb3_q[DLAT_W-1] ? QW'(-dxb3_q) : QW'(dxb3_q);
    mag_lng = dyb3_q[DLNG_W-1] ? QW'(-dyb3_q) : QW'(dyb3_q);
    num_u   = num_q[DEN_W-1:0];
    if (degen3_q) begin
      where_d = cps_pkg::WHERE_DEGEN;
    end else if (num_q[NUM_W-1]) begin
      where_d = cps_pkg::WHERE_CLAMP_A;
    end else if (num_q > $signed({1'b0, c3_q.den})) begin
      where_d = cps_pkg::WHERE_CLAMP_B;
    end else begin
      where_d = cps_pkg::WHERE_INTERIOR;
    end
    prod_lat = PW'(lat_lo_q) + {lat_hi_q[PW-HALF_W-1:0], HALF_W'(0)};
    prod_lng = PW'(lng_lo_q) + {lng_hi_q[PW-HALF_W-1:0], HALF_W'(0)};
    c3_d       = c2_q;
    c3_d.den   = DEN_W'(bxx_q) + DEN_W'(byy_q);
    c4_d       = c3_q;
    c4_d.where = where_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1
    c1_q.a_lat <= a_lat_i;
    c1_q.a_lng <= a_lng_i;
    c1_q.b_lat <= b_lat_i;
    c1_q.b_lng <= b_lng_i;
    c1_q.where <= cps_pkg::WHERE_INTERIOR;
    c1_q.den   <= '0;
    dxp_q      <= DLAT_W'(p_lat_i) - DLAT_W'(a_lat_i);
    dyp_q      <= DLNG_W'(p_lng_i) - DLNG_W'(a_lng_i);
    dxb1_q     <= DLAT_W'(b_lat_i) - DLAT_W'(a_lat_i);
    dyb1_q     <= DLNG_W'(b_lng_i) - DLNG_W'(a_lng_i);
    degen1_q   <= (a_lat_i == b_lat_i) && (a_lng_i == b_lng_i);
    // Stage 2
    c2_q     <= c1_q;
    dxb2_q   <= dxb1_q;
    dyb2_q   <= dyb1_q;
    degen2_q <= degen1_q;
    pxx_q    <= dxp_q * dxb1_q;
    pyy_q    <= dyp_q * dyb1_q;
    bxx_q    <= dxb1_q * dxb1_q;
    byy_q    <= dyb1_q * dyb1_q;
    // Stage 3
    c3_q     <= c3_d;
    dxb3_q   <= dxb2_q;
    dyb3_q   <= dyb2_q;
    degen3_q <= degen2_q;
    num_q    <= NUM_W'(pxx_q) + NUM_W'(pyy_q);
    // Stage 4: num is cut in two halves against each magnitude.
    c4_q       <= c4_d;
    lat_lo_q   <= QW'(num_u[HALF_W-1:0]) * mag_lat;
    lat_hi_q   <= QW'(num_u[DEN_W-1:HALF_W]) * mag_lat;
    lng_lo_q   <= QW'(num_u[HALF_W-1:0]) * mag_lng;
    lng_hi_q   <= QW'(num_u[DEN_W-1:HALF_W]) * mag_lng;
    lat_neg4_q <= dxb3_q[DLAT_W-1];
    lng_neg4_q <= dyb3_q[DLNG_W-1];
    // Stage 5: sum of partials, loaded into the divider lanes.
    c5_q      <= c4_q;
    lat_o.rem <= prod_lat[PW-1:QW];
    lat_o.dvd <= prod_lat[QW-1:0];
    lat_o.quo <= '0;
    lat_o.neg <= lat_neg4_q;
    lng_o.rem <= prod_lng[PW-1:QW];
    lng_o.dvd <= prod_lng[QW-1:0];
    lng_o.quo <= '0;
    lng_o.neg <= lng_neg4_q;
  end

  assign valid_o = vld_q[4];
  assign ctx_o   = c5_q;

endmodule

[rtl/cps_div_stage.sv]
// One restoring division step for both coordinate lanes, registered.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cps_pkg::cps_ctx_t  ctx_i,
  input  cps_pkg::cps_lane_t lat_i,
  input  cps_pkg::cps_lane_t lng_i,
  output logic               valid_o,
  output cps_pkg::cps_ctx_t  ctx_o,
  output cps_pkg::cps_lane_t lat_o,
  output cps_pkg::cps_lane_t lng_o
);

  localparam int DEN_W = cps_pkg::DEN_W;
  localparam int QW    = cps_pkg::QW;

  logic               valid_q;
  cps_pkg::cps_ctx_t  ctx_q;
  cps_pkg::cps_lane_t lat_q, lat_d, lng_q, lng_d;

  function automatic cps_pkg::cps_lane_t step(cps_pkg::cps_lane_t l,
                                              logic [DEN_W-1:0] den);
    logic [DEN_W:0]     ext;
    logic [DEN_W:0]     dif;
    logic               ge;
    cps_pkg::cps_lane_t n;
    ext   = {l.rem, l.dvd[QW-1]};
    dif   = ext - {1'b0, den};
    ge    = (ext >= {1'b0, den});
    n.rem = ge ? dif[DEN_W-1:0] : ext[DEN_W-1:0];
    n.dvd = {l.dvd[QW-2:0], 1'b0};
    n.quo = {l.quo[QW-2:0], ge};
    n.neg = l.neg;
    return n;
  endfunction

  assign lat_d = step(lat_i, ctx_i.den);
  assign lng_d = step(lng_i, ctx_i.den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_i;
    lat_q <= lat_d;
    lng_q <= lng_d;
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;
  assign lat_o   = lat_q;
  assign lng_o   = lng_q;

endmodule

[rtl/cps_back.sv]
// Back end: signed quotient, round half away from zero, endpoint selection.
// Two register stages; depends on cps_pkg.
`timescale 1ns / 1ps

module cps_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  cps_pkg::cps_ctx_t                ctx_i,
  input  cps_pkg::cps_lane_t               lat_i,
  input  cps_pkg::cps_lane_t               lng_i,
  output logic                             valid_o,
  output logic signed [cps_pkg::LAT_W-1:0] near_lat_o,
  output logic signed [cps_pkg::LNG_W-1:0] near_lng_o,
  output logic [1:0]                       where_code_o
);

  localparam int LAT_W = cps_pkg::LAT_W;
  localparam int LNG_W = cps_pkg::LNG_W;
  localparam int DEN_W = cps_pkg::DEN_W;
  localparam int QS_W  = cps_pkg::QS_W;

  logic                    v1_q, v2_q;
  cps_pkg::cps_ctx_t       c1_q;
  logic signed [QS_W-1:0]  qlat_q, qlng_q, qlat_d, qlng_d;
  logic [DEN_W-1:0]        rlat_q, rlng_q, rlat_d, rlng_d;
  logic signed [LAT_W-1:0] lat_q, lat_d;
  logic signed [LNG_W-1:0] lng_q, lng_d;
  logic [1:0]              where_q;

  // Floor quotient and its nonnegative remainder for a negative direction.
  function automatic logic signed [QS_W-1:0] sq(cps_pkg::cps_lane_t l);
    logic signed [QS_W-1:0] m;
    m = $signed(QS_W'(l.quo));
    if (!l.neg) begin
      return m;
    end else if (l.rem == '0) begin
      return -m;
    end else begin
      return -m - QS_W'(1);
    end
  endfunction

  function automatic logic [DEN_W-1:0] sr(cps_pkg::cps_lane_t l,
                                          logic [DEN_W-1:0] den);
    if (l.neg && (l.rem != '0)) begin
      return den - l.rem;
    end else begin
      return l.rem;
    end
  endfunction

  function automatic logic signed [QS_W-1:0] rnd(logic signed [QS_W-1:0] a,
                                                 logic signed [QS_W-1:0] q,
                                                 logic [DEN_W-1:0] r,
                                                 logic [DEN_W-1:0] den);
    logic signed [QS_W-1:0] v;
    logic                   up;
    v  = a + q;
    up = ({r, 1'b0} > {1'b0, den}) || (({r, 1'b0} == {1'b0, den}) && !v[QS_W-1]);
    return v + QS_W'(up);
  endfunction

  always_comb begin
    qlat_d = sq(lat_i);
    qlng_d = sq(lng_i);
    rlat_d = sr(lat_i, ctx_i.den);
    rlng_d = sr(lng_i, ctx_i.den);
    unique case (c1_q.where)
      cps_pkg::WHERE_INTERIOR: begin
        lat_d = LAT_W'(rnd(QS_W'(c1_q.a_lat), qlat_q, rlat_q, c1_q.den));
        lng_d = LNG_W'(rnd(QS_W'(c1_q.a_lng), qlng_q, rlng_q, c1_q.den));
      end
      cps_pkg::WHERE_CLAMP_B: begin
        lat_d = c1_q.b_lat;
        lng_d = c1_q.b_lng;
      end
      default: begin
        lat_d = c1_q.a_lat;
        lng_d = c1_q.a_lng;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= ctx_i;
    qlat_q  <= qlat_d;
    qlng_q  <= qlng_d;
    rlat_q  <= rlat_d;
    rlng_q  <= rlng_d;
    lat_q   <= lat_d;
    lng_q   <= lng_d;
    where_q <= c1_q.where;
  end

  assign valid_o      = v2_q;
  assign near_lat_o   = lat_q;
  assign near_lng_o   = lng_q;
  assign where_code_o = where_q;

endmodule
